// ===== sv/ratb_pkg.sv =====
// Shared types and constants for the region adjacency table builder.
// Used by the controller, the datapath and the top level; no dependencies.
package ratb_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned LABEL_W = 10;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned DIST_W  = 8;

  // Number of neighbor slots visible on the result ports.
  localparam int unsigned SHOWN_SLOTS = 4;

  // Parameter defaults.
  localparam int unsigned MAX_LABELS_DEF = 1024;
  localparam int unsigned SLOTS_DEF      = 4;

  // Run state and register reset values.
  localparam logic [COLOR_W-1:0] RUN_COLOR_RESET = 8'd127;
  localparam logic [DIST_W-1:0]  GAP_MAX         = 8'd255;
  localparam logic [DIST_W-1:0]  MAX_DIST_RESET  = 8'd10;

  // Operation codes carried by the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_PIXEL = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // item taken this cycle
    logic clr_en;  // clear pass writes one entry
    logic rec_a;   // first entry data ready: update it, fetch the second
    logic rec_b;   // second entry data ready: update it
    logic rd_out;  // entry data ready for a read result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic link;      // current pixel links two regions
    logic clr_last;  // clear pass is on its last entry
  } sts_t;

endpackage

// ===== sv/ratb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; a read and a write to the same address return the old data.
module ratb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ratb_ctrl.sv =====
// Controller state machine of the region adjacency table builder.
// Depends on ratb_pkg for the command and status structs and the mode codes.
module ratb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [ratb_pkg::MODE_W-1:0]   mode_i,
  input  ratb_pkg::sts_t                sts_i,
  output ratb_pkg::cmd_t                cmd_o,
  output logic                          busy,
  output logic                          done_o
);
  import ratb_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_REC_A,
    ST_REC_B
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  mode_e  mode;
  logic   accept;

  assign mode   = mode_e'(mode_i);
  assign accept = start && (state_q == ST_IDLE);

  // Next state and result strobe.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_READ: state_d = ST_READ;
            MODE_PIXEL: begin
              done_d = 1'b1;
              if (sts_i.link) state_d = ST_REC_A;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_REC_A: state_d = ST_REC_B;
      ST_REC_B: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State and registered strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.accept = accept;
    cmd_o.clr_en = (state_q == ST_CLEAR);
    cmd_o.rec_a  = (state_q == ST_REC_A);
    cmd_o.rec_b  = (state_q == ST_REC_B);
    cmd_o.rd_out = (state_q == ST_READ);
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_rec_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REC_A |=> state_q == ST_REC_B)
    else $error("first entry update not followed by second");
  a_link_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode == MODE_PIXEL && sts_i.link) |=> (state_q == ST_REC_A && done_q))
    else $error("linking pixel did not start the table update");
  a_no_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !done_q)
    else $error("result strobe during clear pass");
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> done_q)
    else $error("read did not deliver a result");
`endif

endmodule

// ===== sv/ratb_dp.sv =====
// Datapath of the region adjacency table builder: run state, neighbor table
// memory, entry update logic and result registers. Uses ratb_pkg and ratb_ram.
module ratb_dp #(
  parameter int unsigned MAX_LABELS = ratb_pkg::MAX_LABELS_DEF,
  parameter int unsigned SLOTS      = ratb_pkg::SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ratb_pkg::cmd_t                 cmd_i,
  output ratb_pkg::sts_t                 sts_o,
  input  logic [ratb_pkg::MODE_W-1:0]    mode_i,
  input  logic [ratb_pkg::LABEL_W-1:0]   label_i,
  input  logic [ratb_pkg::COLOR_W-1:0]   color_i,
  input  logic                           line_start_i,
  input  logic [ratb_pkg::LABEL_W-1:0]   entry_index_i,
  input  logic                           cfg_valid_i,
  input  logic [ratb_pkg::DIST_W-1:0]    cfg_data_i,
  output logic                           linked_o,
  output logic [ratb_pkg::LABEL_W-1:0]   neighbor_a_o,
  output logic [ratb_pkg::LABEL_W-1:0]   neighbor_b_o,
  output logic [ratb_pkg::LABEL_W-1:0]   neighbor_c_o,
  output logic [ratb_pkg::LABEL_W-1:0]   neighbor_d_o,
  output logic                           overflowed_o
);
  import ratb_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LABELS);
  localparam int unsigned EW = SLOTS * LABEL_W + 1;

  // Record a neighbor into an entry: skip a duplicate, fill the first empty
  // slot, or set the overflow mark when every slot is taken.
  function automatic logic [EW-1:0] rec_fn(logic [EW-1:0] ent,
                                           logic [LABEL_W-1:0] other);
    logic [EW-1:0] r;
    logic          hit;
    r   = ent;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit) begin
        if (ent[i*LABEL_W +: LABEL_W] == other) begin
          hit = 1'b1;
        end else if (ent[i*LABEL_W +: LABEL_W] == '0) begin
          r[i*LABEL_W +: LABEL_W] = other;
          hit = 1'b1;
        end
      end
    end
    if (!hit) r[EW-1] = 1'b1;
    return r;
  endfunction

  mode_e mode;
  assign mode = mode_e'(mode_i);

  // Configuration register.
  logic [DIST_W-1:0] max_dist_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MAX_DIST_RESET;
    end else if (cfg_valid_i) begin
      max_dist_q <= cfg_data_i;
    end
  end

  // Run state as seen by this pixel, after an optional line start.
  logic [LABEL_W-1:0] prev_label_q, prev_label_d, eff_label;
  logic [COLOR_W-1:0] prev_color_q, prev_color_d, eff_color;
  logic [DIST_W-1:0]  gap_q, gap_d, eff_gap;
  logic               link;

  assign eff_label = line_start_i ? '0 : prev_label_q;
  assign eff_color = line_start_i ? RUN_COLOR_RESET : prev_color_q;
  assign eff_gap   = line_start_i ? '0 : gap_q;

  assign link = (label_i != '0) && (label_i != eff_label) && (eff_label != '0) &&
                (eff_color != color_i) && (eff_gap <= max_dist_q);

  // Run state update for a pixel.
  always_comb begin
    prev_label_d = eff_label;
    prev_color_d = eff_color;
    gap_d        = eff_gap;
    if (label_i == '0) begin
      if (eff_gap != GAP_MAX) gap_d = eff_gap + DIST_W'(1);
    end else if (label_i == eff_label) begin
      gap_d = DIST_W'(1);
    end else begin
      prev_label_d = label_i;
      prev_color_d = color_i;
      gap_d        = DIST_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_label_q <= '0;
      prev_color_q <= RUN_COLOR_RESET;
      gap_q        <= '0;
    end else if (cmd_i.accept && mode == MODE_PIXEL) begin
      prev_label_q <= prev_label_d;
      prev_color_q <= prev_color_d;
      gap_q        <= gap_d;
    end
  end

  // Clear pass counter, walks every entry once after reset.
  logic [AW-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign sts_o.link     = link;
  assign sts_o.clr_last = (clr_cnt_q == AW'(MAX_LABELS - 1));

  // The two owners of a link and whether their entries exist.
  logic               idx_ok, lbl_ok, prev_ok;
  logic [LABEL_W-1:0] own_a_q, own_b_q;
  logic               a_ok_q, b_ok_q, idx_ok_q;

  assign idx_ok  = 32'(entry_index_i) < 32'(MAX_LABELS);
  assign lbl_ok  = 32'(label_i) < 32'(MAX_LABELS);
  assign prev_ok = 32'(eff_label) < 32'(MAX_LABELS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      own_a_q  <= eff_label;
      own_b_q  <= label_i;
      a_ok_q   <= prev_ok;
      b_ok_q   <= lbl_ok;
      idx_ok_q <= idx_ok;
    end
  end

  // Memory port selection.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    ram_raddr = AW'(entry_index_i);
    if (cmd_i.clr_en) begin
      ram_we = 1'b1;
    end else if (cmd_i.accept) begin
      if (mode == MODE_CLEAR) begin
        ram_we    = idx_ok;
        ram_waddr = AW'(entry_index_i);
      end
      if (mode == MODE_PIXEL) begin
        ram_raddr = AW'(eff_label);
      end
    end else if (cmd_i.rec_a) begin
      ram_we    = a_ok_q;
      ram_waddr = AW'(own_a_q);
      ram_wdata = rec_fn(ram_rdata, own_b_q);
      ram_raddr = AW'(own_b_q);
    end else if (cmd_i.rec_b) begin
      ram_we    = b_ok_q;
      ram_waddr = AW'(own_b_q);
      ram_wdata = rec_fn(ram_rdata, own_a_q);
    end
  end

  ratb_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_LABELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Visible slots of the entry just read; absent slots show as empty.
  logic [LABEL_W-1:0] rd_nb [SHOWN_SLOTS];
  for (genvar j = 0; j < SHOWN_SLOTS; j++) begin : g_view
    if (j < SLOTS) begin : g_slot
      assign rd_nb[j] = ram_rdata[j*LABEL_W +: LABEL_W];
    end else begin : g_empty
      assign rd_nb[j] = '0;
    end
  end

  // Result registers.
  logic               linked_q, ovf_q;
  logic [LABEL_W-1:0] nb_q [SHOWN_SLOTS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      linked_q <= (mode == MODE_PIXEL) && link;
      ovf_q    <= 1'b0;
      for (int k = 0; k < SHOWN_SLOTS; k++) nb_q[k] <= '0;
    end else if (cmd_i.rd_out) begin
      linked_q <= 1'b0;
      ovf_q    <= ram_rdata[EW-1] & idx_ok_q;
      for (int k = 0; k < SHOWN_SLOTS; k++) nb_q[k] <= idx_ok_q ? rd_nb[k] : '0;
    end
  end

  assign linked_o     = linked_q;
  assign neighbor_a_o = nb_q[0];
  assign neighbor_b_o = nb_q[1];
  assign neighbor_c_o = nb_q[2];
  assign neighbor_d_o = nb_q[3];
  assign overflowed_o = ovf_q;

endmodule

// ===== sv/region_adjacency_table_builder.sv =====
// Top level of the region adjacency table builder.
// Joins ratb_ctrl and ratb_dp; uses ratb_pkg for widths and struct types.
//
// Usage: an item is taken at a clock edge with start high and busy low.
// mode 0 feeds one labelled pixel in scan order, mode 1 reads the neighbor
// entry at entry_index, mode 2 clears it, mode 3 does nothing. Every item
// gives one result beat, shown for one cycle with done_o high.
// Timing: a pixel, a clear or a no-op gives its result the cycle after
// start and the next item may follow at once. A read passes through the
// READ state and gives its result as it leaves it, with busy high in that
// state. A pixel that links two regions gives its result the next cycle
// but holds busy through the REC_A and REC_B states: the table memory's
// single read port reads the two owner entries one after the other and
// each is rewritten in turn.
// Configuration: max_distance is written on the cfg channel, which is always
// ready; write it only while no item is in progress.
// Reset: the run state and max_distance (10) reset at once; the table is then
// cleared one entry a cycle, every entry in turn, while busy stays high.
// The receiver cannot stall: each result beat must be taken when shown.
module region_adjacency_table_builder #(
  parameter int unsigned MAX_LABELS = ratb_pkg::MAX_LABELS_DEF,
  parameter int unsigned SLOTS      = ratb_pkg::SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [ratb_pkg::MODE_W-1:0]    mode_i,
  input  logic [ratb_pkg::LABEL_W-1:0]   label_i,
  input  logic [ratb_pkg::COLOR_W-1:0]   color_i,
  input  logic                           line_start_i,
  input  logic [ratb_pkg::LABEL_W-1:0]   entry_index_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ratb_pkg::DIST_W-1:0]    cfg_data_i,
  output logic                           done_o,
  output logic                           linked_o,
  output logic [ratb_pkg::LABEL_W-1:0]   neighbor_a_o,
  output logic [ratb_pkg::LABEL_W-1:0]   neighbor_b_o,
  output logic [ratb_pkg::LABEL_W-1:0]   neighbor_c_o,
  output logic [ratb_pkg::LABEL_W-1:0]   neighbor_d_o,
  output logic                           overflowed_o
);
  import ratb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The register write always completes in the cycle it is offered.
  assign cfg_ready_o = 1'b1;

  ratb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  ratb_dp #(
    .MAX_LABELS (MAX_LABELS),
    .SLOTS      (SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .label_i       (label_i),
    .color_i       (color_i),
    .line_start_i  (line_start_i),
    .entry_index_i (entry_index_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .linked_o      (linked_o),
    .neighbor_a_o  (neighbor_a_o),
    .neighbor_b_o  (neighbor_b_o),
    .neighbor_c_o  (neighbor_c_o),
    .neighbor_d_o  (neighbor_d_o),
    .overflowed_o  (overflowed_o)
  );

endmodule
